// File: rtl/core/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared status codes and the queue entry type of the completion frontier
// tracker.
// ----------------------------------------------------------------------------
package cft_pkg;

	localparam int STATUS_W  = 2;
	// widest bit position the window can need (window of up to 1024 numbers)
	localparam int POS_W_MAX = 10;

	localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_STALE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [POS_W_MAX-1:0] pos;
	} cft_item_t;

endpackage

// File: rtl/core/cft_front.sv
// ----------------------------------------------------------------------------
// cft_front
// Accepts a completion request and classifies it against the frontier:
// zero, stale, beyond the window, or a bit position inside the window.
// ----------------------------------------------------------------------------
module cft_front #(
	parameter int WINDOW = 64
) (
	input  logic              accept,
	input  logic [63:0]       done_number,
	input  logic [63:0]       frontier,
	output logic              push,
	output cft_pkg::cft_item_t item
);
	import cft_pkg::*;

	logic [63:0] offset;
	logic [63:0] pos_full;

	assign offset   = done_number - frontier;
	assign pos_full = offset - 64'd1;
	assign push     = accept;

	always_comb begin
		item.pos = pos_full[POS_W_MAX-1:0];
		if (done_number == 64'd0) begin
			item.status = ST_ZERO;
		end else if (done_number <= frontier) begin
			item.status = ST_STALE;
		end else if (offset > 64'(WINDOW)) begin
			item.status = ST_BEYOND;
		end else begin
			item.status = ST_STORED;
		end
	end

endmodule

// File: rtl/core/cft_queue.sv
// ----------------------------------------------------------------------------
// cft_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module cft_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cft_pkg::cft_item_t item_in,
	input  logic              pop,
	output cft_pkg::cft_item_t item_out,
	output logic              empty
);
	import cft_pkg::*;

	cft_item_t   slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign empty    = (count_q == 2'd0);
	assign item_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/cft_back.sv
// ----------------------------------------------------------------------------
// cft_back
// Holds the frontier and the pending bitmap. Sets the bit of a stored
// request, then walks the frontier over the run of completed numbers one
// chunk of up to 64 bits per cycle.
// ----------------------------------------------------------------------------
module cft_back #(
	parameter int WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cft_pkg::cft_item_t            item,
	input  logic                          empty,
	output logic                          pop,
	output logic                          idle,
	output logic [63:0]                   frontier,
	output logic                          strobe,
	output logic                          raised,
	output logic [cft_pkg::STATUS_W-1:0]  status
);
	import cft_pkg::*;

	localparam int PW    = $clog2(WINDOW);
	localparam int CHUNK = (WINDOW < 64) ? WINDOW : 64;
	localparam int RW    = $clog2(CHUNK + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [WINDOW-1:0] pend_q;
	logic [63:0]       frontier_q;
	logic              strobe_q;
	logic              raised_q;
	logic [STATUS_W-1:0] status_q;
	logic [RW-1:0]     run;
	logic [WINDOW-1:0] set_bit;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign idle     = (state_q == ST_IDLE);
	assign frontier = frontier_q;
	assign strobe   = strobe_q;
	assign raised   = raised_q;
	assign status   = status_q;
	assign set_bit  = {{(WINDOW-1){1'b0}}, 1'b1} << item.pos[PW-1:0];

	// trailing ones over the low chunk of the bitmap
	always_comb begin
		run = RW'(CHUNK);
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (!pend_q[i]) begin
				run = RW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_q     <= '0;
			frontier_q <= 64'd0;
			strobe_q   <= 1'b0;
			raised_q   <= 1'b0;
			status_q   <= ST_STORED;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						raised_q <= 1'b0;
						status_q <= item.status;
						if (item.status == ST_STORED) begin
							pend_q  <= pend_q | set_bit;
							state_q <= ST_SCAN;
						end else begin
							strobe_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					pend_q     <= pend_q >> run;
					frontier_q <= frontier_q + 64'(run);
					if (run != '0) begin
						raised_q <= 1'b1;
					end
					// a chunk not all ones ends the run
					if (run != RW'(CHUNK)) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/completion_frontier_tracker.sv
// ----------------------------------------------------------------------------
// completion_frontier_tracker
// Tracks out-of-order job completions and publishes the cumulative frontier.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; it
//   carries done_number. Exactly one result follows, shown for one cycle with
//   result_strobe high: frontier, raised and status (0 stored, 1 stale,
//   2 zero, 3 beyond the window of WINDOW numbers above the frontier).
//   frontier also stays valid between results.
// Flow:
//   zero, stale and beyond-window requests pass from the front through the
//   queue to the back end, which registers the strobe and the result.
//   A stored request sets its bitmap bit, then advances the frontier by up to
//   64 numbers per cycle until it reaches a number not yet completed, then strobes.
//   The rate is set by the chunked trailing-ones scan of the bitmap.
//   busy stays high from the accept until the back end is idle again, so no
//   new request is taken before the last one has its result.
// Reset:
//   arst_n clears the frontier to zero and the pending bitmap to empty.
//   Results cannot be held off; the receiver must take each strobe.
// ----------------------------------------------------------------------------
module completion_frontier_tracker #(
	parameter int WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [63:0]                   done_number,
	output logic                          result_strobe,
	output logic [63:0]                   frontier,
	output logic                          raised,
	output logic [cft_pkg::STATUS_W-1:0]  status
);
	import cft_pkg::*;

	logic      accept;
	logic      push;
	logic      pop;
	logic      empty;
	logic      back_idle;
	cft_item_t front_item;
	cft_item_t queue_item;

	assign accept = start && !busy;
	assign busy   = !empty || !back_idle;

	cft_front #(
		.WINDOW(WINDOW)
	) u_front (
		.accept     (accept),
		.done_number(done_number),
		.frontier   (frontier),
		.push       (push),
		.item       (front_item)
	);

	cft_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (front_item),
		.pop     (pop),
		.item_out(queue_item),
		.empty   (empty)
	);

	cft_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (queue_item),
		.empty   (empty),
		.pop     (pop),
		.idle    (back_idle),
		.frontier(frontier),
		.strobe  (result_strobe),
		.raised  (raised),
		.status  (status)
	);

endmodule
